// ----- sv/pcls_pkg.sv -----
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types and constants for the pitch-class locked shift block.
// ----------------------------------------------------------------------------
package pcls_pkg;

	// configuration register indexes
	localparam logic REG_MAX_SHIFT = 1'b0;
	localparam logic REG_STRENGTH  = 1'b1;

	localparam logic [13:0] MAX_SHIFT_RST = 14'd3072;
	localparam logic [8:0]  STRENGTH_RST  = 9'd256;

	// strength is unsigned Q1.8
	localparam int STR_FRAC  = 8;
	localparam int STR_ROUND = 1 << (STR_FRAC - 1);

	// result saturation bounds
	localparam int SHIFT_POS_MAX = 16383;
	localparam int SHIFT_NEG_MAG = 16384;

	// one input beat; last field in the lowest bits
	typedef struct packed {
		logic signed [3:0]  preferred_octaves;
		logic               previous_valid;
		logic signed [14:0] previous_shift;
		logic               target_valid;
		logic [14:0]        target_pitch;
		logic               vocal_valid;
		logic [14:0]        vocal_pitch;
	} in_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_REM,
		OP_DIST,
		OP_NEAR,
		OP_HI_NUM,
		OP_HI_SUB,
		OP_LO_NUM,
		OP_LO_ADD,
		OP_MUL,
		OP_RND
	} op_t;

	typedef struct packed {
		logic above;
		logic below;
	} stat_t;

endpackage

// ----- sv/pcls_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcls_ctrl
// Sequencer: steps the datapath through one correction and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module pcls_ctrl
	import pcls_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output op_t   op
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_QE   = 13'b0000000000010,
		ST_REM  = 13'b0000000000100,
		ST_DIST = 13'b0000000001000,
		ST_QA   = 13'b0000000010000,
		ST_NEAR = 13'b0000000100000,
		ST_FOLD = 13'b0000001000000,
		ST_HID  = 13'b0000010000000,
		ST_HIA  = 13'b0000100000000,
		ST_LOD  = 13'b0001000000000,
		ST_LOA  = 13'b0010000000000,
		ST_MUL  = 13'b0100000000000,
		ST_RND  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op      = OP_LOAD;
					state_d = ST_QE;
				end
			end
			ST_QE: begin
				op      = OP_DIV;
				state_d = ST_REM;
			end
			ST_REM: begin
				op      = OP_REM;
				state_d = ST_DIST;
			end
			ST_DIST: begin
				op      = OP_DIST;
				state_d = ST_QA;
			end
			ST_QA: begin
				op      = OP_DIV;
				state_d = ST_NEAR;
			end
			ST_NEAR: begin
				op      = OP_NEAR;
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				priority if (stat.above) begin
					op      = OP_HI_NUM;
					state_d = ST_HID;
				end else if (stat.below) begin
					op      = OP_LO_NUM;
					state_d = ST_LOD;
				end else begin
					op      = OP_MUL;
					state_d = ST_RND;
				end
			end
			ST_HID: begin
				op      = OP_DIV;
				state_d = ST_HIA;
			end
			ST_HIA: begin
				op      = OP_HI_SUB;
				state_d = ST_FOLD;
			end
			ST_LOD: begin
				op      = OP_DIV;
				state_d = ST_LOA;
			end
			ST_LOA: begin
				op      = OP_LO_ADD;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				op      = OP_MUL;
				state_d = ST_RND;
			end
			ST_RND: begin
				if (!out_valid_q || m_tready) begin
					op      = OP_RND;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_RND)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_RND |-> !out_valid_q || m_tready)
		else $error("result register overwritten before taken");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_RND |=> m_tvalid)
		else $error("written result not presented");

endmodule

// ----- sv/pcls_dpath.sv -----
// ----------------------------------------------------------------------------
// pcls_dpath
// Datapath: pitch-class remainder, octave placement, range folding and
// strength scaling, with one shared divide-by-octave unit.
// ----------------------------------------------------------------------------
module pcls_dpath
	import pcls_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  in_item_t    item,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [13:0] wr_data,
	output stat_t       stat,
	output logic [14:0] result
);

	localparam int OCT  = 12 << FRAC_BITS;
	localparam int HALF = OCT / 2;
	localparam int WI   = (FRAC_BITS + 9 > 18) ? FRAC_BITS + 9 : 18;
	localparam int SH   = FRAC_BITS + 2;
	localparam int DW   = WI - SH - 1;
	localparam int PW   = WI + 9;

	localparam logic signed [WI-1:0] OCT_S  = WI'(OCT);
	localparam logic signed [WI-1:0] HALF_S = WI'(HALF);
	localparam logic signed [WI-1:0] OCTM1  = WI'(OCT - 1);

	// floor(x / 3), exact for x below 2^15
	function automatic logic [14:0] div3(input logic [14:0] x);
		logic [29:0] p;
		p = {15'd0, x} * 30'd21846;
		return {1'b0, p[29:16]};
	endfunction

	logic [13:0]          max_q;
	logic [8:0]           str_q;
	logic                 vld_q;
	logic                 neg_q;
	logic [WI-1:0]        mag_q;
	logic [DW-1:0]        q_q;
	logic signed [WI-1:0] ref_q;
	logic signed [WI-1:0] r_q;
	logic signed [WI-1:0] c_q;
	logic signed [PW-1:0] p_q;
	logic [14:0]          res_q;

	logic signed [WI-1:0] m_s;
	logic signed [WI-1:0] qo;
	logic signed [WI-1:0] d;
	logic signed [WI-1:0] rm;
	logic [WI:0]          rm2;
	logic                 inc;
	logic signed [WI-1:0] rr;
	logic signed [WI-1:0] a;
	logic [PW-1:0]        mp;
	logic [PW-1:0]        sm;
	logic [14:0]          sres;

	assign m_s = $signed(WI'(max_q));
	assign qo  = $signed({{(WI-DW){1'b0}}, q_q}) * OCT_S;
	assign d   = $signed(WI'(item.target_pitch)) - $signed(WI'(item.vocal_pitch));
	assign rm  = $signed(mag_q) - qo;
	assign rm2 = {rm, 1'b0};
	assign inc = (rm2 > (WI+1)'(OCT)) || ((rm2 == (WI+1)'(OCT)) && q_q[0]);
	assign rr  = inc ? rm - OCT_S : rm;
	assign a   = ref_q - r_q;

	assign mp = p_q[PW-1] ? $unsigned(-p_q) : $unsigned(p_q);
	assign sm = (mp + PW'(STR_ROUND)) >> STR_FRAC;

	always_comb begin
		priority if (!vld_q)
			sres = '0;
		else if (p_q[PW-1])
			sres = (sm > PW'(SHIFT_NEG_MAG)) ? 15'(-SHIFT_NEG_MAG) : 15'(-sm);
		else
			sres = (sm > PW'(SHIFT_POS_MAX)) ? 15'(SHIFT_POS_MAX) : sm[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SHIFT_RST;
			str_q <= STRENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_SHIFT: max_q <= wr_data;
				REG_STRENGTH:  str_q <= wr_data[8:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				vld_q <= item.vocal_valid & item.target_valid;
				neg_q <= d[WI-1];
				mag_q <= d[WI-1] ? $unsigned(-d) : $unsigned(d);
				ref_q <= item.previous_valid ? WI'($signed(item.previous_shift))
					: WI'($signed(item.preferred_octaves)) * OCT_S;
			end
			OP_DIV: q_q <= DW'(div3(15'(mag_q[WI-2:SH])));
			OP_REM: r_q <= neg_q ? -rr : rr;
			OP_DIST: begin
				neg_q <= a[WI-1];
				mag_q <= $unsigned((a[WI-1] ? -a : a) + HALF_S);
			end
			OP_NEAR:   c_q <= r_q + (neg_q ? -qo : qo);
			OP_HI_NUM: mag_q <= $unsigned(c_q - m_s + OCTM1);
			OP_HI_SUB: c_q <= c_q - qo;
			OP_LO_NUM: mag_q <= $unsigned(-m_s - c_q + OCTM1);
			OP_LO_ADD: c_q <= c_q + qo;
			OP_MUL:    p_q <= PW'(c_q) * PW'($signed({1'b0, str_q}));
			OP_RND:    res_q <= sres;
			default:   ;
		endcase
	end

	assign stat.above = c_q > m_s;
	assign stat.below = c_q < -m_s;
	assign result     = res_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(op) == OP_REM |-> (r_q <= HALF_S) && (r_q >= -HALF_S))
		else $error("pitch-class remainder out of half-octave range");

	a_fold_hi: assert property (@(posedge clk) disable iff (!arst_n)
		$past(op) == OP_HI_SUB |-> !stat.above)
		else $error("downward fold left value above limit");

	a_fold_lo: assert property (@(posedge clk) disable iff (!arst_n)
		$past(op) == OP_LO_ADD |-> !stat.below)
		else $error("upward fold left value below limit");

endmodule

// ----- sv/pitch_class_locked_shift.sv -----
// ----------------------------------------------------------------------------
// pitch_class_locked_shift
// Pitch correction locked to pitch class, placed by octave and scaled.
// ----------------------------------------------------------------------------
// One item at a time. Each item is stepped through load, octave divide,
// remainder, distance, octave divide and nearest placement, then scaling and
// rounding; each fold toward the +-max_shift window adds a numerator, a divide
// and an adjust step, set by the sequencer stepping one shared divide-by-octave unit.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register, and the next beat is taken while it waits. A second
// result finished before the first is taken holds the sequencer, and with it
// the input.
// Write wr_index 0 (max_shift) or 1 (strength) only while the block is idle.
// ----------------------------------------------------------------------------
module pitch_class_locked_shift
	import pcls_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// vocal_pitch, vocal_valid, target_pitch, target_valid, previous_shift,
	// previous_valid, preferred_octaves, zero pad
	input  logic [55:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// shift_amount, zero pad
	output logic [15:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [13:0] wr_data
);

	in_item_t    item;
	op_t         op;
	stat_t       stat;
	logic [14:0] result;

	assign item = in_item_t'(s_tdata[51:0]);

	pcls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.op       (op)
	);

	pcls_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.stat     (stat),
		.result   (result)
	);

	assign m_tdata = {1'b0, result};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pitch-class locked shift block.
// A directed set covers invalid pitches, quotient ties, octave-reference ties,
// field extremes and folding. Random beats then run under several max_shift
// and strength settings, including zero, full scale and over-unity strength.
// Every accepted beat is predicted in the bench and checked against the
// result stream in order. Both stream sides idle at random, and one long
// receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb
	import pcls_pkg::*;
;

	localparam int     FRAC_BITS = 8;
	localparam longint OCT       = longint'(12) << FRAC_BITS;
	localparam int     DRAIN     = 24;
	localparam int     LIMIT     = 1000000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic [55:0] s_tdata  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = REG_MAX_SHIFT;
	logic [13:0] wr_data  = '0;

	// settings mirrored for prediction
	logic [13:0] cfg_max_shift = MAX_SHIFT_RST;
	logic [8:0]  cfg_strength  = STRENGTH_RST;

	in_item_t    beat_q[$];
	logic [14:0] shift_q[$];

	int  drv_wait   = 0;
	int  rcv_wait   = 0;
	bit  drv_steady = 1'b0;
	bit  rcv_steady = 1'b0;
	bit  hold_off   = 1'b0;
	int  beats_in   = 0;
	int  results    = 0;
	int  errors     = 0;
	int  phases     = 0;
	int  cycles     = 0;
	logic [14:0] want;

	pitch_class_locked_shift #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// quotient by one octave, nearest, ties to even
	function automatic longint oct_quot_even(longint a);
		longint m, q, rm;
		m = a < 0 ? -a : a;
		q = m / OCT;
		rm = m % OCT;
		if (rm * 2 > OCT || (rm * 2 == OCT && (q % 2) == 1))
			q++;
		return a < 0 ? -q : q;
	endfunction

	// quotient by one octave, nearest, ties away from zero
	function automatic longint oct_quot_away(longint a);
		longint m, q;
		m = a < 0 ? -a : a;
		q = (m + OCT / 2) / OCT;
		return a < 0 ? -q : q;
	endfunction

	function automatic logic [14:0] locked_shift(in_item_t it, logic [13:0] ms,
			logic [8:0] st);
		longint d, r, rf, c, p, s, m, k;
		if (!it.vocal_valid || !it.target_valid)
			return '0;
		m = ms;
		k = st;
		d = longint'(it.target_pitch) - longint'(it.vocal_pitch);
		r = d - oct_quot_even(d) * OCT;
		if (it.previous_valid)
			rf = longint'($signed(it.previous_shift));
		else
			rf = OCT * longint'($signed(it.preferred_octaves));
		c = r + OCT * oct_quot_away(rf - r);
		if (c > m)
			c -= ((c - m + OCT - 1) / OCT) * OCT;
		if (c < -m)
			c += ((-m - c + OCT - 1) / OCT) * OCT;
		p = c * k;
		if (p < 0)
			s = -((-p + STR_ROUND) >> STR_FRAC);
		else
			s = (p + STR_ROUND) >> STR_FRAC;
		if (s > SHIFT_POS_MAX)
			s = SHIFT_POS_MAX;
		if (s < -SHIFT_NEG_MAG)
			s = -SHIFT_NEG_MAG;
		return s[14:0];
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(99);
		if (k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	function automatic in_item_t random_beat();
		in_item_t it;
		int k, off;
		it.vocal_pitch = 15'($urandom_range(32767));
		k = $urandom_range(9);
		if (k < 3)
			off = 1536 * $urandom_range(20) - 15360;
		else if (k < 6)
			off = $urandom_range(4000) - 2000;
		else
			off = $urandom_range(32767) - int'(it.vocal_pitch);
		it.target_pitch = 15'(int'(it.vocal_pitch) + off);
		it.vocal_valid = $urandom_range(9) != 0;
		it.target_valid = $urandom_range(9) != 0;
		it.previous_valid = $urandom_range(4) < 3;
		k = $urandom_range(2);
		if (k == 0)
			it.previous_shift = 15'($urandom_range(32767));
		else if (k == 1)
			it.previous_shift = 15'($urandom_range(24576) - 12288);
		else
			it.previous_shift = 15'(1536 * ($urandom_range(16) - 8)
				+ $urandom_range(8) - 4);
		it.preferred_octaves = 4'($urandom_range(15));
		return it;
	endfunction

	task automatic add_beat(int v, bit vv, int t, bit tv, int ps, bit pv, int po);
		in_item_t it;
		it.vocal_pitch = 15'(v);
		it.vocal_valid = vv;
		it.target_pitch = 15'(t);
		it.target_valid = tv;
		it.previous_shift = 15'(ps);
		it.previous_valid = pv;
		it.preferred_octaves = 4'(po);
		beat_q.push_back(it);
	endtask

	task automatic write_reg(logic idx, logic [13:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic settle();
		while (beat_q.size() != 0 || s_tvalid || shift_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		phases++;
	endtask

	task automatic run_phase(logic [13:0] ms, logic [8:0] st, int n, bit steady);
		write_reg(REG_MAX_SHIFT, ms);
		write_reg(REG_STRENGTH, {5'b0, st});
		cfg_max_shift <= ms;
		cfg_strength <= st;
		drv_steady <= steady;
		rcv_steady <= steady;
		@(negedge clk);
		repeat (n) beat_q.push_back(random_beat());
		settle();
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			drv_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				shift_q.push_back(locked_shift(in_item_t'(s_tdata[51:0]),
					cfg_max_shift, cfg_strength));
				beats_in <= beats_in + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (drv_wait != 0) begin
					s_tvalid <= 1'b0;
					drv_wait <= drv_wait - 1;
				end else if (beat_q.size() != 0) begin
					s_tdata <= {4'b0, beat_q.pop_front()};
					s_tvalid <= 1'b1;
					drv_wait <= drv_steady ? 0 : gap_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rcv_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results <= results + 1;
				if (shift_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("ERROR: unexpected beat shift_amount=%0d",
							$signed(m_tdata[14:0]));
				end else begin
					want = shift_q.pop_front();
					if (m_tdata[14:0] !== want) begin
						errors = errors + 1;
						if (errors <= 10)
							$display("ERROR: shift_amount expected %0d got %0d",
								$signed(want), $signed(m_tdata[14:0]));
					end
				end
			end
			if (rcv_wait != 0) begin
				m_tready <= 1'b0;
				rcv_wait <= rcv_wait - 1;
			end else begin
				m_tready <= !hold_off;
				if (!rcv_steady && $urandom_range(3) == 0)
					rcv_wait <= gap_len();
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		while (beats_in < 120)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("pitch_class_locked_shift regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings
		add_beat(1000, 0, 2000, 1, 0, 0, 0);
		add_beat(1000, 1, 2000, 0, 0, 0, 0);
		add_beat(32767, 0, 32767, 0, -16384, 1, -8);
		add_beat(6000, 1, 6000, 1, 0, 0, 0);
		add_beat(6000, 1, 7536, 1, 0, 0, 0);
		add_beat(6000, 1, 4464, 1, 0, 0, 0);
		add_beat(6000, 1, 10608, 1, 0, 0, 0);
		add_beat(10608, 1, 6000, 1, 0, 0, 0);
		add_beat(0, 1, 32767, 1, 0, 0, 0);
		add_beat(32767, 1, 0, 1, 0, 0, 0);
		add_beat(5000, 1, 5500, 1, 12288, 1, 0);
		add_beat(5000, 1, 4500, 1, -12288, 1, 0);
		add_beat(5000, 1, 5100, 1, 16383, 1, 0);
		add_beat(5000, 1, 4900, 1, -16384, 1, 0);
		add_beat(5000, 1, 5300, 1, 0, 0, 7);
		add_beat(5000, 1, 5300, 1, 0, 0, -8);
		add_beat(5000, 1, 5300, 1, 0, 0, 4);
		add_beat(5000, 1, 5300, 1, 0, 0, -4);
		add_beat(5000, 1, 5300, 1, 1836, 1, 0);
		add_beat(5300, 1, 5000, 1, -1836, 1, 0);
		add_beat(1000, 1, 2000, 1, 3000, 1, 0);
		add_beat(0, 1, 0, 1, 0, 1, 0);
		add_beat(32767, 1, 32767, 1, 16383, 1, 7);
		settle();

		run_phase(14'd3072, 9'd256, 400, 1'b0);
		run_phase(14'd1536, 9'd0, 150, 1'b0);
		run_phase(14'd12288, 9'd256, 200, 1'b1);
		run_phase(14'd0, 9'd511, 150, 1'b0);
		run_phase(14'd16383, 9'd128, 200, 1'b0);
		run_phase(14'($urandom_range(16383)), 9'($urandom_range(511)), 150, 1'b0);
		run_phase(14'd5000, 9'd1, 150, 1'b0);

		$display("run covered %0d beats over %0d setting phases (max_shift 0..16383,",
			beats_in, phases);
		$display("strength 0..511), %0d results checked, %0d mismatches",
			results, errors);
		if (errors == 0 && shift_q.size() == 0)
			$display("pitch_class_locked_shift regression: pass");
		else
			$display("pitch_class_locked_shift regression: fail");
		$finish;
	end

endmodule
